@@ rtl/bpse_pkg.sv @@
// ----------------------------------------------------------------------------
// bpse_pkg
// Shared constants, queue entry type and rounding helper for the bicubic
// patch surface evaluator.
// ----------------------------------------------------------------------------
package bpse_pkg;

  localparam int MAX_PATCHES = 8;
  localparam int COORD_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DERIV_BITS  = COORD_BITS + 8;
  localparam int GRID_DIM    = 3 * MAX_PATCHES + 1;
  localparam int GRID_CELLS  = GRID_DIM * GRID_DIM;
  localparam int ADDR_W      = $clog2(GRID_CELLS);
  localparam int IDX_W       = $clog2(MAX_PATCHES);
  localparam int PAR_W       = FRAC_BITS + 1;
  localparam int CNT_W       = 4;
  localparam int BAS_W       = FRAC_BITS + 2;  // signed basis 0..1.0
  localparam int DB_W        = FRAC_BITS + 4;  // signed derivative basis
  localparam int WT_W        = FRAC_BITS + 4;  // signed weight
  localparam int MW          = 48;             // working width for products
  localparam int ACC_W       = 64;
  localparam int PT_W        = 3 * COORD_BITS;
  localparam int QDEPTH      = 2;

  localparam logic [PAR_W-1:0] ONE_FX = PAR_W'(1) << FRAC_BITS;
  localparam logic signed [MW-1:0] HALF_MW = MW'(1) <<< (FRAC_BITS - 1);

  // Item kinds carried in tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_PATCH_U = 1'b0;
  localparam logic CFG_PATCH_V = 1'b1;

  typedef struct packed {
    logic                          is_eval;
    logic [ADDR_W-1:0]             waddr;
    logic [PT_W-1:0]               pt;      // z, y, x from high to low
    logic [IDX_W-1:0]              iu;
    logic [IDX_W-1:0]              iv;
    logic [3:0]                    nu;
    logic [3:0]                    nv;
    logic [3:0][BAS_W-1:0]         bu;
    logic [3:0][DB_W-1:0]          du;
    logic [3:0][BAS_W-1:0]         bv;
    logic [3:0][DB_W-1:0]          dv;
  } bpse_entry_t;

  // Round to nearest, ties up: floor((x + half) / 2^F)
  function automatic logic signed [MW-1:0] rnd_fx(input logic signed [MW-1:0] x);
    logic signed [MW-1:0] y;
    y = x + HALF_MW;
    return y >>> FRAC_BITS;
  endfunction

endpackage

@@ rtl/bpse_fifo.sv @@
// ----------------------------------------------------------------------------
// bpse_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module bpse_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bpse_pkg::bpse_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output bpse_pkg::bpse_entry_t head
);
  import bpse_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  bpse_entry_t         slots [QDEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [PW:0]         count;

  assign full      = (count == (PW+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

@@ rtl/bpse_front.sv @@
// ----------------------------------------------------------------------------
// bpse_front
// Accepts items, locates the patch and builds the Bernstein and derivative
// basis for an evaluate; queues evaluates and in-grid writes in order.
// ----------------------------------------------------------------------------
module bpse_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_action,
  input  logic [4:0]              in_row,
  input  logic [4:0]              in_col,
  input  logic [bpse_pkg::PT_W-1:0]  in_pt,
  input  logic [bpse_pkg::PAR_W-1:0] in_u,
  input  logic [bpse_pkg::PAR_W-1:0] in_v,
  input  logic [3:0]              cfg_nu,
  input  logic [3:0]              cfg_nv,
  output logic                    q_push,
  output bpse_pkg::bpse_entry_t   q_data,
  input  logic                    q_full
);
  import bpse_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_LOC, F_SQ, F_BASIS, F_PUSH} fstate_t;

  fstate_t                 state;
  bpse_entry_t             ent;
  logic [PAR_W-1:0]        par   [2];
  logic [3:0]              ncnt  [2];
  logic [PAR_W-1:0]        t_r   [2];
  logic [PAR_W-1:0]        s_r   [2];
  logic [PAR_W-1:0]        tt_r  [2];
  logic [PAR_W-1:0]        ss_r  [2];
  logic [PAR_W-1:0]        ts_r  [2];

  logic [3:0]              n_eff [2];
  logic [IDX_W-1:0]        idx_c [2];
  logic [PAR_W-1:0]        t_c   [2];
  logic [PAR_W-1:0]        tt_c  [2];
  logic [PAR_W-1:0]        ss_c  [2];
  logic [PAR_W-1:0]        ts_c  [2];
  logic [3:0][BAS_W-1:0]   b_c   [2];
  logic [3:0][DB_W-1:0]    d_c   [2];
  logic [ADDR_W-1:0]       waddr_c;
  logic                    wok_c;

  assign in_ready = (state == F_IDLE);
  assign q_push   = (state == F_PUSH) && !q_full;
  assign q_data   = ent;

  // write address and grid bounds
  assign wok_c   = (in_row < 5'(GRID_DIM)) && (in_col < 5'(GRID_DIM));
  assign waddr_c = ADDR_W'(in_row * ADDR_W'(GRID_DIM)) + ADDR_W'(in_col);

  // per-direction arithmetic (u lane 0, v lane 1)
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      logic [PAR_W-1:0]     p;
      logic [PAR_W+3:0]     sc;
      logic [4:0]           ip;
      logic [4:0]           nm1;
      logic signed [MW-1:0] tw, sw, ttw, ssw, tsw, m;
      // patch count clamp: zero acts as one, large acts as the maximum
      if (ncnt[k] == 4'd0) n_eff[k] = 4'd1;
      else if (ncnt[k] > 4'(MAX_PATCHES)) n_eff[k] = 4'(MAX_PATCHES);
      else n_eff[k] = ncnt[k];
      // locate
      p   = (par[k] > ONE_FX) ? ONE_FX : par[k];
      sc  = p * n_eff[k];
      ip  = 5'(sc >> FRAC_BITS);
      nm1 = 5'(n_eff[k]) - 5'd1;
      if (ip > nm1) ip = nm1;
      idx_c[k] = IDX_W'(ip);
      t_c[k]   = PAR_W'(sc - ((PAR_W+4)'(ip) << FRAC_BITS));
      // squares and cross term
      tw  = MW'(t_r[k]);
      sw  = MW'(s_r[k]);
      m   = rnd_fx(tw * tw);  tt_c[k] = PAR_W'(m);
      m   = rnd_fx(sw * sw);  ss_c[k] = PAR_W'(m);
      m   = rnd_fx(tw * sw);  ts_c[k] = PAR_W'(m);
      // basis
      ttw = MW'(tt_r[k]);
      ssw = MW'(ss_r[k]);
      tsw = MW'(ts_r[k]);
      m = rnd_fx(ssw * sw);            b_c[k][0] = BAS_W'(m);
      m = rnd_fx((tsw * sw) * 3);      b_c[k][1] = BAS_W'(m);
      m = rnd_fx((tsw * tw) * 3);      b_c[k][2] = BAS_W'(m);
      m = rnd_fx(ttw * tw);            b_c[k][3] = BAS_W'(m);
      m = -(ssw * 3);                  d_c[k][0] = DB_W'(m);
      m = ssw * 3 - tsw * 6;           d_c[k][1] = DB_W'(m);
      m = tsw * 6 - ttw * 3;           d_c[k][2] = DB_W'(m);
      m = ttw * 3;                     d_c[k][3] = DB_W'(m);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            ent.is_eval <= (in_action == ACT_EVAL);
            ent.waddr   <= waddr_c;
            ent.pt      <= in_pt;
            par[0]      <= in_u;
            par[1]      <= in_v;
            ncnt[0]     <= cfg_nu;
            ncnt[1]     <= cfg_nv;
            if (in_action == ACT_EVAL) state <= F_LOC;
            else if (wok_c) state <= F_PUSH;
          end
        end
        F_LOC: begin
          for (int k = 0; k < 2; k++) begin
            t_r[k] <= t_c[k];
            s_r[k] <= ONE_FX - t_c[k];
          end
          ent.iu <= idx_c[0];
          ent.iv <= idx_c[1];
          ent.nu <= n_eff[0];
          ent.nv <= n_eff[1];
          state  <= F_SQ;
        end
        F_SQ: begin
          for (int k = 0; k < 2; k++) begin
            tt_r[k] <= tt_c[k];
            ss_r[k] <= ss_c[k];
            ts_r[k] <= ts_c[k];
          end
          state <= F_BASIS;
        end
        F_BASIS: begin
          ent.bu <= b_c[0];
          ent.du <= d_c[0];
          ent.bv <= b_c[1];
          ent.dv <= d_c[1];
          state  <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/bpse_back.sv @@
// ----------------------------------------------------------------------------
// bpse_back
// Carries out queued items: stores control points, and for an evaluate
// sweeps the 16 patch points through a shared multiply-accumulate.
// ----------------------------------------------------------------------------
module bpse_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  bpse_pkg::bpse_entry_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [335:0]          out_data
);
  import bpse_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_RUN, B_DRAIN, B_SCALE, B_FIN} bstate_t;

  bstate_t                 state;
  bpse_entry_t             job;
  logic [CNT_W-1:0]        cnt;
  logic                    v1, v2;
  logic [PT_W-1:0]         mem [GRID_CELLS];
  logic [PT_W-1:0]         rdata;
  logic signed [WT_W-1:0]  w_r   [3];
  logic signed [ACC_W-1:0] prod  [3][3];
  logic signed [ACC_W-1:0] acc   [3][3];
  logic signed [ACC_W-1:0] scl   [3][3];
  logic                    mem_we;

  logic [4:0]              row_c, col_c;
  logic [ADDR_W-1:0]       raddr;
  logic signed [WT_W-1:0]  w_c   [3];
  logic signed [COORD_BITS-1:0] res_pos [3];
  logic signed [DERIV_BITS-1:0] res_du  [3];
  logic signed [DERIV_BITS-1:0] res_dv  [3];

  assign mem_we = (state == B_IDLE) && q_valid && !q_head.is_eval;
  assign q_pop  = (state == B_IDLE) && q_valid;

  // point address and weights for step cnt (a = cnt[3:2], b = cnt[1:0])
  always_comb begin
    logic signed [MW-1:0] bua, dua, bvb, dvb, m;
    row_c = 5'(job.iu) * 5'd3 + 5'(cnt[3:2]);
    col_c = 5'(job.iv) * 5'd3 + 5'(cnt[1:0]);
    raddr = ADDR_W'(row_c * ADDR_W'(GRID_DIM)) + ADDR_W'(col_c);
    bua = MW'($signed(job.bu[cnt[3:2]]));
    dua = MW'($signed(job.du[cnt[3:2]]));
    bvb = MW'($signed(job.bv[cnt[1:0]]));
    dvb = MW'($signed(job.dv[cnt[1:0]]));
    m = rnd_fx(bua * bvb);  w_c[0] = WT_W'(m);
    m = rnd_fx(dua * bvb);  w_c[1] = WT_W'(m);
    m = rnd_fx(bua * dvb);  w_c[2] = WT_W'(m);
  end

  // control point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[q_head.waddr] <= q_head.pt;
    rdata <= mem[raddr];
  end

  // weight and product stages
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      w_r[k] <= w_c[k];
      for (int c = 0; c < 3; c++) begin
        prod[k][c] <= ACC_W'($signed(rdata[c*COORD_BITS +: COORD_BITS])) * ACC_W'(w_r[k]);
      end
    end
  end

  // final rounding and saturation
  always_comb begin
    logic signed [ACC_W-1:0] r;
    for (int c = 0; c < 3; c++) begin
      r = (scl[0][c] + ACC_W'(HALF_MW)) >>> FRAC_BITS;
      if (r > ACC_W'((64'sd1 <<< (COORD_BITS-1)) - 1))
        res_pos[c] = {1'b0, {(COORD_BITS-1){1'b1}}};
      else if (r < -(64'sd1 <<< (COORD_BITS-1)))
        res_pos[c] = {1'b1, {(COORD_BITS-1){1'b0}}};
      else res_pos[c] = COORD_BITS'(r);
      r = (scl[1][c] + ACC_W'(HALF_MW)) >>> FRAC_BITS;
      if (r > ACC_W'((64'sd1 <<< (DERIV_BITS-1)) - 1))
        res_du[c] = {1'b0, {(DERIV_BITS-1){1'b1}}};
      else if (r < -(64'sd1 <<< (DERIV_BITS-1)))
        res_du[c] = {1'b1, {(DERIV_BITS-1){1'b0}}};
      else res_du[c] = DERIV_BITS'(r);
      r = (scl[2][c] + ACC_W'(HALF_MW)) >>> FRAC_BITS;
      if (r > ACC_W'((64'sd1 <<< (DERIV_BITS-1)) - 1))
        res_dv[c] = {1'b0, {(DERIV_BITS-1){1'b1}}};
      else if (r < -(64'sd1 <<< (DERIV_BITS-1)))
        res_dv[c] = {1'b1, {(DERIV_BITS-1){1'b0}}};
      else res_dv[c] = DERIV_BITS'(r);
    end
  end

  // sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= (state == B_RUN);
      v2 <= v1;
      // output valid: set on the final step, cleared once taken
      if ((state == B_FIN) && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (v2) begin
        for (int k = 0; k < 3; k++)
          for (int c = 0; c < 3; c++)
            acc[k][c] <= acc[k][c] + prod[k][c];
      end
      case (state)
        B_IDLE: begin
          if (q_valid && q_head.is_eval) begin
            job <= q_head;
            cnt <= '0;
            for (int k = 0; k < 3; k++)
              for (int c = 0; c < 3; c++)
                acc[k][c] <= '0;
            state <= B_RUN;
          end
        end
        B_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) state <= B_DRAIN;
        end
        B_DRAIN: begin
          if (!v1 && !v2) state <= B_SCALE;
        end
        B_SCALE: begin
          for (int c = 0; c < 3; c++) begin
            scl[0][c] <= acc[0][c];
            scl[1][c] <= acc[1][c] * ACC_W'(job.nu);
            scl[2][c] <= acc[2][c] * ACC_W'(job.nv);
          end
          state <= B_FIN;
        end
        B_FIN: begin
          if (!out_valid || out_ready) begin
            out_data  <= {res_dv[2], res_dv[1], res_dv[0],
                          res_du[2], res_du[1], res_du[0],
                          res_pos[2], res_pos[1], res_pos[0]};
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // product stage only follows a read stage
  a_pipe_order: assert property (@(posedge clk) disable iff (rst) v2 |-> $past(v1))
    else $error("product stage without read stage");
  // queue is drained only between items
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!v1 && !v2))
    else $error("queue popped during evaluation");
  // results are formed only after the sweep has fully drained
  a_scale_drained: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCALE) |-> (!v1 && !v2 && $past(state == B_DRAIN)))
    else $error("scale before accumulation finished");
`endif

endmodule

@@ rtl/bicubic_patch_surface_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// bicubic_patch_surface_evaluator_unit
// Bicubic Bezier surface evaluator over a 25x25 control point grid.
// ----------------------------------------------------------------------------
// A write passes the front sequencer and the queue before it lands in the
//   store. The back part takes a new evaluate only once the last is done,
//   as its 16-step sweep runs the patch points through the single read port
//   and multiply-accumulate.
// Reset: rst (synchronous) clears control state and sets both patch counts
//   to 1; the control point store is not cleared and reads undefined.
module bicubic_patch_surface_evaluator_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  // [4:0] grid_row, [9:5] grid_col, [41:10] point_x, [73:42] point_y,
  // [105:74] point_z, [122:106] param_u, [139:123] param_v, rest zero
  input  logic [143:0]   s_tdata,
  // [0] action
  input  logic           s_tuser,
  output logic           m_tvalid,
  input  logic           m_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [135:96] du_x, [175:136] du_y,
  // [215:176] du_z, [255:216] dv_x, [295:256] dv_y, [335:296] dv_z
  output logic [335:0]   m_tdata,
  input  logic           cfg_wr_en,
  input  logic           cfg_index,
  input  logic [3:0]     cfg_wdata
);
  import bpse_pkg::*;

  logic [3:0]   patches_u, patches_v;
  logic         q_push, q_full, q_pop, q_valid;
  bpse_entry_t  q_in, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      patches_u <= 4'd1;
      patches_v <= 4'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PATCH_U: patches_u <= cfg_wdata;
        CFG_PATCH_V: patches_v <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bpse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_row    (s_tdata[4:0]),
    .in_col    (s_tdata[9:5]),
    .in_pt     ({s_tdata[105:74], s_tdata[73:42], s_tdata[41:10]}),
    .in_u      (s_tdata[122:106]),
    .in_v      (s_tdata[139:123]),
    .cfg_nu    (patches_u),
    .cfg_nv    (patches_v),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_full    (q_full)
  );

  bpse_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  bpse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
